>>> src/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg: shared types for the counted multiset table
// Command, status and cell operation codes, plus the structs that travel
// between the table control and the row of storage cells.
// ----------------------------------------------------------------------------
package cmt_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		CMD_FIND     = 2'd0,
		CMD_FIND_ALL = 2'd1,
		CMD_ADD      = 2'd2,
		CMD_REMOVE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	// Operation applied by the cells for one cycle
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_INC   = 2'd1,
		OP_DEC   = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	// Broadcast from the control to every cell
	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} bcast_t;

	// Passed from each cell to its right-hand neighbor
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] count;
		logic             free_seen;
	} chain_t;

endpackage

>>> src/cmt_cell.sv
// ----------------------------------------------------------------------------
// cmt_cell: one entry of the counted multiset table
// Holds a key, its duplicate count and a valid bit, compares against the
// broadcast key, and forwards hit, count and free status to its neighbor.
// ----------------------------------------------------------------------------
module cmt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  cmt_pkg::bcast_t bcast,
	input  cmt_pkg::chain_t chain_in,
	output cmt_pkg::chain_t chain_out,
	output logic            hit
);

	logic                      valid_q;
	logic [cmt_pkg::CNT_W-1:0] count_q;
	logic [cmt_pkg::KEY_W-1:0] key_q;
	logic                      hit_q;
	logic                      claim;

	// Claim this entry when it is the lowest free one
	assign claim = (bcast.op == cmt_pkg::OP_ALLOC) && !valid_q && !chain_in.free_seen;

	// Merge this cell into the chain
	always_comb begin
		chain_out.hit       = chain_in.hit | hit_q;
		chain_out.count     = chain_in.count | (hit_q ? count_q : '0);
		chain_out.free_seen = chain_in.free_seen | !valid_q;
	end

	assign hit = hit_q;

	// Compare, then update count and valid on the broadcast operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			hit_q <= valid_q && (key_q == bcast.key);
			unique case (bcast.op)
				cmt_pkg::OP_INC: begin
					if (hit_q) begin
						count_q <= count_q + 1'b1;
					end
				end
				cmt_pkg::OP_DEC: begin
					if (hit_q) begin
						if (count_q > 1) begin
							count_q <= count_q - 1'b1;
						end else begin
							count_q <= '0;
							valid_q <= 1'b0;
						end
					end
				end
				cmt_pkg::OP_ALLOC: begin
					if (claim) begin
						valid_q <= 1'b1;
						count_q <= cmt_pkg::CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key store, written on allocation only
	always_ff @(posedge clk) begin
		if (claim) begin
			key_q <= bcast.key;
		end
	end

endmodule

>>> src/counted_multiset_table_top.sv
// ----------------------------------------------------------------------------
// counted_multiset_table_top: bag of distinct keys with duplicate counts
// Each input transaction carries one command (tuser) and one key (tdata).
// Every command goes through these steps from acceptance to its first result:
// compare the key in all ENTRIES cells at once, gather hit, count and free
// status along the row of cells, and the first output cycle, in which the
// table is updated. Find, add and remove give one result; find_all gives
// one result per duplicate, one per output transaction. The next command is
// accepted once the last result of the current one has been taken. The row
// of cells is ripple connected, so ENTRIES sets the longest path.
// ----------------------------------------------------------------------------
module counted_multiset_table_top #(
	parameter int ENTRIES = 16,
	parameter int MAX_DUP = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] key
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [31:0] value, [32] found, [39:33] dup_count,
	                              // [41:40] status, [47:42] zero
	output logic        m_tlast
);

	localparam logic [cmt_pkg::CNT_W-1:0] MAX_C = cmt_pkg::CNT_W'(MAX_DUP);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_MATCH  = 4'b0010,
		S_DECIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t                    state_q;
	cmt_pkg::cmd_t             cmd_q;
	logic [cmt_pkg::KEY_W-1:0] key_q;
	cmt_pkg::op_t              op_q;
	logic [cmt_pkg::KEY_W-1:0] value_q;
	logic                      found_q;
	logic [cmt_pkg::CNT_W-1:0] dup_q;
	cmt_pkg::status_t          status_q;
	logic [cmt_pkg::CNT_W-1:0] rem_q;

	cmt_pkg::bcast_t           bcast;
	cmt_pkg::chain_t           chain [ENTRIES+1];
	logic [ENTRIES-1:0]        hit_vec;

	logic                      c_hit;
	logic [cmt_pkg::CNT_W-1:0] c_cnt;
	logic                      c_full;

	cmt_pkg::op_t              d_op;
	logic [cmt_pkg::KEY_W-1:0] d_value;
	logic                      d_found;
	logic [cmt_pkg::CNT_W-1:0] d_dup;
	cmt_pkg::status_t          d_status;
	logic [cmt_pkg::CNT_W-1:0] d_rem;

	// Row of cells
	assign bcast.op  = op_q;
	assign bcast.key = key_q;
	assign chain[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		cmt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.hit       (hit_vec[i])
		);
	end

	assign c_hit  = chain[ENTRIES].hit;
	assign c_cnt  = chain[ENTRIES].count;
	assign c_full = !chain[ENTRIES].free_seen;

	// Decide the result and the cell operation
	always_comb begin
		d_op     = cmt_pkg::OP_NONE;
		d_value  = '0;
		d_found  = 1'b0;
		d_dup    = '0;
		d_status = cmt_pkg::ST_MISS;
		d_rem    = cmt_pkg::CNT_W'(1);
		unique case (cmd_q)
			cmt_pkg::CMD_FIND: begin
				if (c_hit) begin
					d_value  = key_q;
					d_found  = 1'b1;
					d_dup    = c_cnt;
					d_status = cmt_pkg::ST_OK;
				end
			end
			cmt_pkg::CMD_FIND_ALL: begin
				if (c_hit) begin
					d_value  = key_q;
					d_found  = 1'b1;
					d_dup    = c_cnt;
					d_status = cmt_pkg::ST_OK;
					priority if (c_cnt > MAX_C) begin
						d_rem = MAX_C;
					end else if (c_cnt == '0) begin
						d_rem = cmt_pkg::CNT_W'(1);
					end else begin
						d_rem = c_cnt;
					end
				end
			end
			cmt_pkg::CMD_ADD: begin
				if (c_hit) begin
					d_value = key_q;
					d_found = 1'b1;
					if (c_cnt >= MAX_C) begin
						d_dup    = MAX_C;
						d_status = cmt_pkg::ST_SAT;
					end else begin
						d_dup    = c_cnt + 1'b1;
						d_status = cmt_pkg::ST_OK;
						d_op     = cmt_pkg::OP_INC;
					end
				end else if (c_full) begin
					d_status = cmt_pkg::ST_FULL;
				end else begin
					d_dup    = cmt_pkg::CNT_W'(1);
					d_status = cmt_pkg::ST_OK;
					d_op     = cmt_pkg::OP_ALLOC;
				end
			end
			cmt_pkg::CMD_REMOVE: begin
				if (c_hit) begin
					d_value  = key_q;
					d_found  = 1'b1;
					d_dup    = c_cnt - 1'b1;
					d_status = cmt_pkg::ST_OK;
					d_op     = cmt_pkg::OP_DEC;
				end
			end
			default: begin
			end
		endcase
	end

	// Control sequence and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= cmt_pkg::OP_NONE;
			rem_q   <= '0;
		end else begin
			op_q <= cmt_pkg::OP_NONE;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					op_q    <= d_op;
					rem_q   <= d_rem;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (m_tready) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == cmt_pkg::CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the command and hold the result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmt_pkg::cmd_t'(s_tuser);
			key_q <= s_tdata;
		end
		if (state_q == S_DECIDE) begin
			value_q  <= d_value;
			found_q  <= d_found;
			dup_q    <= d_dup;
			status_q <= d_status;
		end
	end

	// Ports
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_EMIT);
	assign m_tlast  = (rem_q == cmt_pkg::CNT_W'(1));
	assign m_tdata  = {6'd0, status_q, dup_q, found_q, value_q};

`ifndef SYNTHESIS
	// Keys are distinct, so at most one cell may hit
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("more than one cell matched the key");

	// A cell operation lasts exactly one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		op_q != cmt_pkg::OP_NONE |=> op_q == cmt_pkg::OP_NONE)
		else $error("cell operation held for more than one cycle");

	// Input and output sides never overlap
	assert property (@(posedge clk) disable iff (!arst_n) !(s_tready && m_tvalid))
		else $error("input accepted while results pending");

	// While emitting, at least one result remains
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> rem_q != '0)
		else $error("result counter empty during emit");
`endif

endmodule
